// ===== hdl/assert_macros.svh =====
// Assertion macros used by the back (bdb_back) of the bayer dither binarizer RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hdl/bdb_pkg.sv =====
// Package for the bayer dither binarizer: job type, register codes, threshold
// and reciprocal functions. No dependencies.

package bdb_pkg;

    localparam int MAX_RANK_LOG2_DEF = 3;
    localparam int PHASE_W = 3;
    localparam int Q_W = 7;
    localparam int THR_W = 6;
    localparam int RECIP_W = 15;
    localparam int RECIP_SHIFT = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CFG_RANK_LOG2 = 1'b0;
    localparam logic CFG_ORDERED_MODE = 1'b1;

    localparam logic [1:0] BAYER_QUAD [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    typedef struct packed {
        logic [Q_W-1:0]     q;
        logic               ordered;
        logic [1:0]         rank_log2;
        logic [PHASE_W-1:0] row;
        logic [PHASE_W-1:0] col;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Bayer threshold at (x, y); low index bits select the most significant digit.
    function automatic logic [THR_W-1:0] bayer_at(input logic [PHASE_W-1:0] x,
                                                  input logic [PHASE_W-1:0] y,
                                                  input logic [1:0] n);
        logic [THR_W-1:0] v;
        v = '0;
        for (int b = 0; b < PHASE_W; b++) begin
            if (2'(b) < n) begin
                v = {v[THR_W-3:0], BAYER_QUAD[{x[b], y[b]}]};
            end
        end
        return v;
    endfunction

    // ceil(2^16 / (256 / (rank*rank + 1))), exact quotient for 8-bit pixels
    function automatic logic [RECIP_W-1:0] step_recip(input logic [1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            2'd2:    m = 15'd4370;
            2'd3:    m = 15'd21846;
            default: m = 15'd1286;
        endcase
        return m;
    endfunction

    function automatic logic [PHASE_W-1:0] rank_mask(input logic [1:0] n);
        logic [PHASE_W-1:0] m;
        case (n)
            2'd2:    m = 3'b011;
            2'd3:    m = 3'b111;
            default: m = 3'b001;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/bdb_queue.sv =====
// Two-entry job queue between front and back of the bayer dither binarizer.
// Depends on bdb_pkg.

module bdb_queue
    import bdb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_st
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               w_push;
    logic               w_pop;

    assign o_st.empty = (r_count == '0);
    assign o_st.full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign w_push     = i_push && !o_st.full;
    assign w_pop      = i_pop && !o_st.empty;
    assign o_job      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/bdb_front.sv =====
// Front of the bayer dither binarizer: configuration registers, pixel
// quantization and frame phases. Depends on bdb_pkg.

module bdb_front
    import bdb_pkg::*;
#(
    parameter int P_MAX_RANK_LOG2 = MAX_RANK_LOG2_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_valid,
    input  logic [7:0] i_pixel,
    input  logic       i_end_of_row,
    input  logic       i_start_of_frame,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]                 r_rank_log2;
    logic                       r_ordered_mode;
    logic [PHASE_W-1:0]         r_row_phase;
    logic [PHASE_W-1:0]         r_col_phase;
    logic [PHASE_W-1:0]         n_row_phase;
    logic [PHASE_W-1:0]         n_col_phase;
    logic [PHASE_W-1:0]         w_row_base;
    logic [PHASE_W-1:0]         w_col_base;
    logic [1:0]                 w_n;
    logic [PHASE_W-1:0]         w_mask;
    logic [8+RECIP_W-1:0]       w_prod;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        if (r_rank_log2 == 2'd0) begin
            w_n = 2'd1;
        end else if (r_rank_log2 > 2'(P_MAX_RANK_LOG2)) begin
            w_n = 2'(P_MAX_RANK_LOG2);
        end else begin
            w_n = r_rank_log2;
        end
    end

    assign w_mask     = rank_mask(w_n);
    assign w_row_base = i_start_of_frame ? '0 : r_row_phase;
    assign w_col_base = i_start_of_frame ? '0 : r_col_phase;
    assign w_prod     = (8 + RECIP_W)'(i_pixel) * (8 + RECIP_W)'(step_recip(w_n));

    always_comb begin
        o_job.q         = w_prod[RECIP_SHIFT +: Q_W];
        o_job.ordered   = r_ordered_mode;
        o_job.rank_log2 = w_n;
        o_job.row       = w_row_base & w_mask;
        o_job.col       = w_col_base & w_mask;
    end

    always_comb begin
        if (i_end_of_row) begin
            n_row_phase = w_row_base + 1'b1;
            n_col_phase = '0;
        end else begin
            n_row_phase = w_row_base;
            n_col_phase = w_col_base + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_log2    <= 2'd1;
            r_ordered_mode <= 1'b0;
            r_row_phase    <= '0;
            r_col_phase    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_RANK_LOG2:    r_rank_log2    <= i_cfg_wdata;
                    CFG_ORDERED_MODE: r_ordered_mode <= i_cfg_wdata[0];
                    default:          r_rank_log2    <= r_rank_log2;
                endcase
            end
            if (o_push) begin
                r_row_phase <= n_row_phase;
                r_col_phase <= n_col_phase;
            end
        end
    end

endmodule

// ===== hdl/bdb_back.sv =====
// Back of the bayer dither binarizer: threshold compare, pattern cell walk and
// output register. Depends on bdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bdb_back
    import bdb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_q_status  i_q_st,
    output logic       o_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // white, sub_row[2:0], sub_col[2:0], zero pad
    output logic       m_axis_tlast    // last
);

    logic [PHASE_W-1:0] r_x;
    logic [PHASE_W-1:0] r_y;
    logic [PHASE_W-1:0] n_x;
    logic [PHASE_W-1:0] n_y;
    logic               r_out_valid;
    logic               r_white;
    logic [PHASE_W-1:0] r_sub_row;
    logic [PHASE_W-1:0] r_sub_col;
    logic               r_last;
    logic               w_emit;
    logic [PHASE_W-1:0] w_mask;
    logic [PHASE_W-1:0] w_tx;
    logic [PHASE_W-1:0] w_ty;
    logic [THR_W-1:0]   w_thr;
    logic               w_last;

    assign w_emit = !i_q_st.empty && (!r_out_valid || m_axis_tready);
    assign w_mask = rank_mask(i_job.rank_log2);
    assign w_tx   = i_job.ordered ? i_job.row : r_x;
    assign w_ty   = i_job.ordered ? i_job.col : r_y;
    assign w_thr  = bayer_at(w_tx, w_ty, i_job.rank_log2);
    assign w_last = i_job.ordered || ((r_x == w_mask) && (r_y == w_mask));
    assign o_pop  = w_emit && w_last;

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (w_emit && !i_job.ordered) begin
            if (w_last) begin
                n_x = '0;
                n_y = '0;
            end else if (r_y == w_mask) begin
                n_x = r_x + 1'b1;
                n_y = '0;
            end else begin
                n_y = r_y + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_white   <= ({1'b0, i_job.q} > (Q_W + 1)'(w_thr));
            r_sub_row <= i_job.ordered ? '0 : r_x;
            r_sub_col <= i_job.ordered ? '0 : r_y;
            r_last    <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_sub_col, r_sub_row, r_white};
    assign m_axis_tlast  = r_last;

    `ASSERT_NEXT(a_pop_shows_last, i_clk, i_rst_n, o_pop, m_axis_tvalid && m_axis_tlast, "pop without last result")
    `ASSERT_IMPL(a_walk_idle_zero, i_clk, i_rst_n, i_q_st.empty, (r_x == '0) && (r_y == '0), "cell walk not reset")
    `ASSERT_IMPL(a_walk_in_cell, i_clk, i_rst_n, w_emit && !i_job.ordered, ((r_x & ~w_mask) == '0) && ((r_y & ~w_mask) == '0), "cell walk out of range")

endmodule

// ===== hdl/bayer_dither_binarizer.sv =====
// Top level of the bayer dither binarizer: front, job queue and back.
// Depends on bdb_pkg, bdb_front, bdb_queue and bdb_back.

// Gray pixels enter on the s_axis side, one per transaction; each is quantized
// and compared against a Bayer threshold matrix of rank 2, 4 or 8. In ordered
// mode one result leaves per pixel and the block sustains one pixel per cycle;
// in pattern mode a pixel yields rank*rank results, one per cycle from the single
// output register; both hold while the output is not stalled. A two-entry job
// queue separates the quantizing front from the result back, so input is taken
// while results wait. Configuration writes take effect at once; the user must
// make them while no transaction is in flight, as the block does not enforce it.

module bayer_dither_binarizer
    import bdb_pkg::*;
#(
    parameter int P_MAX_RANK_LOG2 = MAX_RANK_LOG2_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [1:0] i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // pixel[7:0]
    input  logic       s_axis_tlast,   // end_of_row
    input  logic       s_axis_tuser,   // start_of_frame
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // white, sub_row[2:0], sub_col[2:0], zero pad
    output logic       m_axis_tlast    // last
);

    logic      w_push;
    logic      w_pop;
    t_job      w_job_in;
    t_job      w_job_out;
    t_q_status w_q_st;

    bdb_front #(
        .P_MAX_RANK_LOG2 (P_MAX_RANK_LOG2)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (s_axis_tvalid),
        .i_pixel          (s_axis_tdata),
        .i_end_of_row     (s_axis_tlast),
        .i_start_of_frame (s_axis_tuser),
        .i_q_full         (w_q_st.full),
        .o_ready          (s_axis_tready),
        .o_push           (w_push),
        .o_job            (w_job_in)
    );

    bdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_st    (w_q_st)
    );

    bdb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_job_out),
        .i_q_st        (w_q_st),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/bayer_dither_binarizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bayer_dither_binarizer: directed and random pixel streams
// in ordered and pattern mode, checked against an in-bench dither predictor.
// Depends on bdb_pkg and the bayer_dither_binarizer RTL.

module bayer_dither_binarizer_tb
    import bdb_pkg::*;
();

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned RANDOM_PIXELS = 85;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_addr;
    logic [1:0] i_cfg_wdata;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // pixel[7:0]
    logic       s_axis_tlast;   // end_of_row
    logic       s_axis_tuser;   // start_of_frame
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // white, sub_row[2:0], sub_col[2:0], zero pad
    logic       m_axis_tlast;   // last

    typedef struct {
        logic       white;
        logic [2:0] sub_row;
        logic [2:0] sub_col;
        logic       last;
    } t_dither_bit;

    class t_dither_board;
        logic [1:0]  rank_log2_reg;
        logic        ordered_reg;
        logic [2:0]  row_phase;
        logic [2:0]  col_phase;
        t_dither_bit pending_bits[$];
        int unsigned mismatches;

        function new();
            rank_log2_reg = 2'd1;
            ordered_reg = 1'b0;
            row_phase = '0;
            col_phase = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic addr, logic [1:0] val);
            if (addr == CFG_RANK_LOG2) begin
                rank_log2_reg = val;
            end else begin
                ordered_reg = val[0];
            end
        endfunction

        function int unsigned pending();
            return pending_bits.size();
        endfunction

        // low index bits pick the most significant base-4 digit
        function logic [5:0] threshold(logic [2:0] r, logic [2:0] c, int unsigned lg);
            logic [5:0] acc;
            logic [1:0] digit;
            acc = '0;
            for (int b = 0; b < lg; b++) begin
                case ({r[b], c[b]})
                    2'b00: digit = 2'd0;
                    2'b01: digit = 2'd2;
                    2'b10: digit = 2'd3;
                    default: digit = 2'd1;
                endcase
                acc = {acc[3:0], digit};
            end
            return acc;
        endfunction

        function void note_pixel(logic [7:0] pixel, logic eor, logic sof);
            int unsigned lg;
            int unsigned rank;
            int unsigned q;
            logic [2:0]  mask;
            t_dither_bit b;
            lg = (rank_log2_reg == 2'd0) ? 1 : rank_log2_reg;
            if (lg > MAX_RANK_LOG2_DEF) lg = MAX_RANK_LOG2_DEF;
            rank = 1 << lg;
            mask = 3'(rank - 1);
            q = pixel / (256 / (rank * rank + 1));
            if (sof) begin
                row_phase = '0;
                col_phase = '0;
            end
            if (ordered_reg) begin
                b.white = (q > threshold(row_phase & mask, col_phase & mask, lg));
                b.sub_row = '0;
                b.sub_col = '0;
                b.last = 1'b1;
                pending_bits.push_back(b);
            end else begin
                for (int x = 0; x < rank; x++) begin
                    for (int y = 0; y < rank; y++) begin
                        b.white = (q > threshold(3'(x), 3'(y), lg));
                        b.sub_row = 3'(x);
                        b.sub_col = 3'(y);
                        b.last = (x == rank - 1) && (y == rank - 1);
                        pending_bits.push_back(b);
                    end
                end
            end
            if (eor) begin
                col_phase = '0;
                row_phase = row_phase + 3'd1;
            end else begin
                col_phase = col_phase + 3'd1;
            end
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_bit(logic [7:0] data, logic last);
            t_dither_bit e;
            if (pending_bits.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual tdata=%h tlast=%b",
                         $time, data, last);
                mismatches++;
                return;
            end
            e = pending_bits.pop_front();
            compare_field("white", e.white, data[0]);
            compare_field("sub_row", e.sub_row, data[3:1]);
            compare_field("sub_col", e.sub_col, data[6:4]);
            compare_field("pad", 0, data[7]);
            compare_field("last", e.last, last);
        endfunction
    endclass

    t_dither_board board = new();

    bit          hold_req;
    bit          sink_steady;
    int unsigned cycle_count;

    bayer_dither_binarizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** bayer_dither_binarizer: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_bit(m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'd255;
        // near the rank-2 quantizer steps
        if (r < 40) return 8'($urandom_range(1, 5) * 51 - $urandom_range(0, 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // output side: random stalls, or one long hold-off on request
    initial begin
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (sink_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] pix, input logic eor, input logic sof,
                              input int unsigned gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tlast <= eor;
        s_axis_tuser <= sof;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_pixel(pix, eor, sof);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input int unsigned cnt, input bit src_steady);
        int unsigned row_len;
        int unsigned col;
        int unsigned gap;
        logic        eor;
        logic        sof;
        row_len = $urandom_range(1, 10);
        col = 0;
        for (int i = 0; i < cnt; i++) begin
            sof = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
            if (sof) col = 0;
            eor = (col == row_len - 1) || ($urandom_range(0, 24) == 0);
            col = eor ? 0 : col + 1;
            gap = src_steady ? 0 : pick_gap();
            if (i == cnt - 1 && gap == 0) gap = 1;
            send_pixel(pick_pixel(), eor, sof, gap);
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] rank_log2, input logic ordered);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_RANK_LOG2;
        i_cfg_wdata <= rank_log2;
        @(posedge i_clk);
        board.set_reg(CFG_RANK_LOG2, rank_log2);
        i_cfg_addr <= CFG_ORDERED_MODE;
        i_cfg_wdata <= {1'b0, ordered};
        @(posedge i_clk);
        board.set_reg(CFG_ORDERED_MODE, {1'b0, ordered});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned cnt;
        logic [1:0]  rl;
        logic        om;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= CFG_RANK_LOG2;
        i_cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        s_axis_tuser <= 1'b0;
        m_axis_tready <= 1'b0;
        cycle_count <= 0;
        hold_req = 1'b0;
        sink_steady = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 2x2 pattern
        send_pixel(8'd0, 1'b0, 1'b1, 0);
        send_pixel(8'd255, 1'b0, 1'b0, 0);
        send_pixel(8'd50, 1'b0, 1'b0, 2);
        send_pixel(8'd51, 1'b1, 1'b0, 1);
        wait_drained();

        // rank code 0 behaves as 2x2, ordered
        write_config(2'd0, 1'b1);
        send_pixel(8'd255, 1'b0, 1'b1, 0);
        send_pixel(8'd0, 1'b1, 1'b0, 0);
        send_pixel(8'd127, 1'b0, 1'b0, 0);
        send_pixel(8'd128, 1'b1, 1'b0, 1);
        wait_drained();

        // 8x8 ordered ramp across a full row, then start of frame mid-row
        write_config(2'd3, 1'b1);
        for (int i = 0; i < 9; i++) begin
            send_pixel(8'(i * 29), (i == 7), (i == 0), 0);
        end
        send_pixel(8'd200, 1'b0, 1'b1, 1);
        wait_drained();

        // 8x8 pattern: all white, all black
        write_config(2'd3, 1'b0);
        send_pixel(8'd255, 1'b0, 1'b1, 0);
        send_pixel(8'd0, 1'b1, 1'b0, 1);
        wait_drained();

        // 4x4 pattern at a step boundary
        write_config(2'd2, 1'b0);
        send_pixel(8'd120, 1'b1, 1'b1, 1);
        wait_drained();

        // output held off while input keeps coming
        random_sent = 24;
        sink_steady = 1'b0;
        write_config(2'd2, 1'b1);
        hold_req = 1'b1;
        send_frame(24, 1'b1);
        wait_drained();

        while (random_sent < RANDOM_PIXELS) begin
            rl = 2'($urandom_range(0, 3));
            om = 1'($urandom_range(0, 1));
            write_config(rl, om);
            sink_steady = ($urandom_range(0, 3) == 0);
            if (om) begin
                cnt = $urandom_range(12, 30);
            end else if (rl == 2'd3) begin
                cnt = $urandom_range(1, 3);
            end else begin
                cnt = $urandom_range(4, 10);
            end
            send_frame(cnt, ($urandom_range(0, 3) == 0));
            random_sent += cnt;
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** bayer_dither_binarizer: PASSED **");
        end else begin
            $display("** bayer_dither_binarizer: FAILED **");
        end
        $finish;
    end

endmodule
